/* hdl/locd_pkg.sv */
// ----------------------------------------------------------------------------
// locd_pkg
// Shared types and constants of the object cache directory.
// ----------------------------------------------------------------------------
package locd_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int STAMP_BITS_DEF = 32;

    localparam int KEY_W  = 64;
    localparam int SIZE_W = 17;
    localparam int SLOT_W = 4;

    localparam logic [SIZE_W-1:0] MAX_OBJECT_RESET = 17'd102400;

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_INSERT = 1'b1
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [KEY_W-1:0]    object_key;
        logic [SIZE_W-1:0]   object_bytes;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   stored_bytes;
        logic                evicted;
        logic                accepted;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

/* hdl/locd_ram.sv */
// ----------------------------------------------------------------------------
// locd_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module locd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lru_object_cache_directory.sv */
// ----------------------------------------------------------------------------
// lru_object_cache_directory
// Fully associative object cache directory with timestamp LRU replacement.
//
// Request channel (i_in_valid / o_in_ready, payload i_in): a lookup or an
// insert. Response channel (o_out_valid / i_out_ready, payload o_out): one
// response per request. Config channel (i_cfg_valid / o_cfg_ready, data
// i_cfg_data) sets the largest object size an insert may store; write it
// only while no request is in flight.
// Each request scans the entry RAM one entry per cycle through its single
// read port, then writes back the chosen entry (an insert, or the hit of a
// lookup; a lookup miss writes nothing). The response is registered after
// the scan, the write-back state and the done state; the next request is
// taken once the block is back in idle. An insert that is too large skips
// the scan and the write-back and goes straight to the done state.
// The response sits in an output register; if the receiver stalls, a
// finished request waits until that register frees up.
// Reset empties every entry at once, clears the stamp counter and restores
// the size limit to 102400; the block takes requests right after reset.
// ----------------------------------------------------------------------------
module lru_object_cache_directory #(
    parameter int ENTRIES    = locd_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = locd_pkg::KEY_BITS_DEF,
    parameter int STAMP_BITS = locd_pkg::STAMP_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  locd_pkg::t_req              i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output locd_pkg::t_rsp              o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [locd_pkg::SIZE_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SZ_W  = locd_pkg::SIZE_W;
    localparam int ENT_W = STAMP_BITS + KEY_BITS + SZ_W;
    localparam logic [CNT_W-1:0]      SCAN_LEN  = CNT_W'(ENTRIES);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    locd_pkg::t_state r_state, n_state;

    logic [SZ_W-1:0]       r_max;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [ENTRIES-1:0]    r_used;

    locd_pkg::t_action     r_action;
    logic [KEY_BITS-1:0]   r_key;
    logic [SZ_W-1:0]       r_bytes;
    logic                  r_refuse;

    logic [CNT_W-1:0]      r_rd_cnt;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;

    logic                  r_found;
    logic [IDX_W-1:0]      r_found_idx;
    logic [SZ_W-1:0]       r_found_size;
    logic                  r_empty_found;
    logic [IDX_W-1:0]      r_empty_idx;
    logic [STAMP_BITS-1:0] r_min_stamp;
    logic [IDX_W-1:0]      r_min_idx;

    locd_pkg::t_rsp        r_out;
    logic                  r_out_vld;

    logic                  in_xfer;
    logic                  out_free;
    logic                  ram_re;
    logic                  ram_we;
    logic                  out_load;
    logic                  scan_end;
    logic [IDX_W-1:0]      ram_raddr;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic [KEY_BITS-1:0]   rd_key;
    logic [SZ_W-1:0]       rd_size;
    logic                  rd_used;
    logic [IDX_W-1:0]      pick;
    logic [STAMP_BITS-1:0] fresh;
    logic                  is_insert;
    locd_pkg::t_rsp        rsp;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_vld || i_out_ready;
    assign is_insert = (r_action == locd_pkg::ACT_INSERT);
    assign scan_end  = (r_rd_cnt == SCAN_LEN) && !r_cmp_vld;
    assign ram_raddr = r_rd_cnt[IDX_W-1:0];
    assign pick      = r_empty_found ? r_empty_idx : r_min_idx;
    assign fresh     = (r_stamp == STAMP_MAX) ? r_stamp : r_stamp + 1'b1;

    assign rd_stamp = ram_rdata[ENT_W-1 -: STAMP_BITS];
    assign rd_key   = ram_rdata[SZ_W +: KEY_BITS];
    assign rd_size  = ram_rdata[SZ_W-1:0];
    assign rd_used  = r_used[r_cmp_idx];

    assign ram_waddr = is_insert ? pick : r_found_idx;
    assign ram_wdata = {fresh, r_key, is_insert ? r_bytes : r_found_size};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            locd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in.action == locd_pkg::ACT_INSERT && i_in.object_bytes > r_max) begin
                        n_state = locd_pkg::ST_DONE;
                    end else begin
                        n_state = locd_pkg::ST_SCAN;
                    end
                end
            end
            locd_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = locd_pkg::ST_WRITE;
                end
            end
            locd_pkg::ST_WRITE: begin
                n_state = locd_pkg::ST_DONE;
            end
            locd_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = locd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = locd_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            locd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            locd_pkg::ST_SCAN: begin
                ram_re = (r_rd_cnt != SCAN_LEN);
            end
            locd_pkg::ST_WRITE: begin
                ram_we = is_insert || r_found;
            end
            locd_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // response fields
    always_comb begin
        rsp = '0;
        if (!r_refuse) begin
            if (is_insert) begin
                rsp.slot     = locd_pkg::SLOT_W'(pick);
                rsp.evicted  = !r_empty_found;
                rsp.accepted = 1'b1;
            end else if (r_found) begin
                rsp.hit          = 1'b1;
                rsp.slot         = locd_pkg::SLOT_W'(r_found_idx);
                rsp.stored_bytes = r_found_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= locd_pkg::ST_IDLE;
            r_max     <= locd_pkg::MAX_OBJECT_RESET;
            r_stamp   <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= ram_re;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (ram_we) begin
                r_stamp            <= fresh;
                r_used[ram_waddr]  <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action      <= i_in.action;
            r_key         <= i_in.object_key[KEY_BITS-1:0];
            r_bytes       <= i_in.object_bytes;
            r_refuse      <= (i_in.action == locd_pkg::ACT_INSERT) && (i_in.object_bytes > r_max);
            r_rd_cnt      <= '0;
            r_found       <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (ram_re) begin
            r_rd_cnt <= r_rd_cnt + 1'b1;
        end
        if (ram_re) begin
            r_cmp_idx <= ram_raddr;
        end
        if (r_cmp_vld) begin
            if (rd_used && rd_key == r_key && !r_found) begin
                r_found      <= 1'b1;
                r_found_idx  <= r_cmp_idx;
                r_found_size <= rd_size;
            end
            if (!rd_used && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_cmp_idx;
            end
            if (r_cmp_idx == '0 || rd_stamp < r_min_stamp) begin
                r_min_stamp <= rd_stamp;
                r_min_idx   <= r_cmp_idx;
            end
        end
        if (out_load) begin
            r_out <= rsp;
        end
    end

    locd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
